// ----- rtl/jpeg_sof_dimension_checker_assert.svh -----
// Assertion macros for the JPEG SOF dimension checker.
`ifndef JPEG_SOF_DIMENSION_CHECKER_ASSERT_SVH
`define JPEG_SOF_DIMENSION_CHECKER_ASSERT_SVH

`ifndef SYNTH
`define JSDC_ASSERT_IMPLY(name, pre, post) \
name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
   else $error("jsdc: implication check failed");
`define JSDC_ASSERT_NEXT(name, pre, post) \
name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
   else $error("jsdc: next-cycle check failed");
`else
`define JSDC_ASSERT_IMPLY(name, pre, post)
`define JSDC_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ----- rtl/jsdc_pkg.sv -----
`default_nettype none
package jsdc_pkg;

   localparam int COUNT_BITS_DEF = 24;

   localparam logic [7:0] MK_FILL  = 8'hff;
   localparam logic [7:0] MK_SOI   = 8'hd8;
   localparam logic [7:0] MK_EOI   = 8'hd9;
   localparam logic [7:0] MK_SOS   = 8'hda;
   localparam logic [7:0] MK_TEM   = 8'h01;
   localparam logic [7:0] MK_RST_LO = 8'hd0;
   localparam logic [7:0] MK_RST_HI = 8'hd7;
   localparam logic [7:0] MK_SOF_LO = 8'hc0;
   localparam logic [7:0] MK_SOF_HI = 8'hcf;
   localparam logic [7:0] MK_DHT   = 8'hc4;
   localparam logic [7:0] MK_JPG   = 8'hc8;
   localparam logic [7:0] MK_DAC   = 8'hcc;

   localparam logic [23:0] MAX_BYTES_RST = 24'd2097152;

   typedef enum logic [3:0] {
      PH_SOI0    = 4'd0,
      PH_SOI1    = 4'd1,
      PH_EXPECT  = 4'd2,
      PH_FILL    = 4'd3,
      PH_LENHI   = 4'd4,
      PH_LENLO   = 4'd5,
      PH_SOFHI   = 4'd6,
      PH_SOFLO   = 4'd7,
      PH_SKIP    = 4'd8,
      PH_SOFBODY = 4'd9,
      PH_DONE    = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_FRAME = 2'd2,
      ERR_SEG   = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      ST_MATCH = 3'd0,
      ST_DIM   = 3'd1,
      ST_FRAME = 3'd2,
      ST_SEG   = 3'd3,
      ST_NOHDR = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_WIDTH     = 2'd0,
      CSR_HEIGHT    = 2'd1,
      CSR_MAX_BYTES = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        matched;
      logic [2:0]  status;
      logic [15:0] found_width;
      logic [15:0] found_height;
   } rsp_type;

   typedef struct packed {
      logic [15:0] expected_width;
      logic [15:0] expected_height;
      logic [23:0] max_image_bytes;
   } cfg_type;

endpackage
`default_nettype wire

// ----- rtl/jpeg_sof_dimension_checker.sv -----
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   req  (data_byte, last_byte)
// rsp       out        rsp_valid / rsp_ready   rsp  (matched, status, found_width/height)
// csr       in         csr_valid / csr_ready   csr_index, csr_wdata
//
// One byte per cycle; the verdict appears in the result register the cycle
// after the last byte is taken. The walk state updates in a single pass per byte.
// Reset (synchronous) clears walk state, width, height, rsp_valid; max bytes gets default.
// Non-final bytes are taken even while a result waits; a final byte waits only
// when the result register is full and rsp_ready is low. csr_ready is always high.
`default_nettype none
`include "jpeg_sof_dimension_checker_assert.svh"
module jpeg_sof_dimension_checker #(
   parameter int COUNT_BITS = jsdc_pkg::COUNT_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire jsdc_pkg::req_type req,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output jsdc_pkg::rsp_type      rsp,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [23:0]       csr_wdata
);

   jsdc_pkg::cfg_type cfg;
   jsdc_pkg::rsp_type result;
   logic              in_fire;
   logic              load;

   assign csr_ready = 1'b1;
   assign req_ready = !req.last_byte || !rsp_valid || rsp_ready;
   assign in_fire   = req_valid && req_ready;
   assign load      = in_fire && req.last_byte;

   jsdc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   jsdc_parser #(
      .COUNT_BITS (COUNT_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .in_fire (in_fire),
      .req     (req),
      .cfg     (cfg),
      .result  (result)
   );

   jsdc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .result    (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   `JSDC_ASSERT_IMPLY(a_no_overwrite, load, (!rsp_valid || rsp_ready))
   `JSDC_ASSERT_NEXT(a_result_follows, load, rsp_valid)
   `JSDC_ASSERT_IMPLY(a_match_flag, rsp_valid, (rsp.matched == (rsp.status == jsdc_pkg::ST_MATCH)))
   `JSDC_ASSERT_IMPLY(a_dims_zeroed,
      (rsp_valid && rsp.status != jsdc_pkg::ST_MATCH && rsp.status != jsdc_pkg::ST_DIM),
      (rsp.found_width == 16'd0 && rsp.found_height == 16'd0))

endmodule
`default_nettype wire

// ----- rtl/jsdc_csr.sv -----
`default_nettype none
module jsdc_csr (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [1:0]               wr_index,
   input  wire logic [23:0]              wr_data,
   output jsdc_pkg::cfg_type             cfg
);

   jsdc_pkg::cfg_type cfg_ff;
   jsdc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (jsdc_pkg::csr_index_type'(wr_index))
            jsdc_pkg::CSR_WIDTH:     cfg_in.expected_width  = wr_data[15:0];
            jsdc_pkg::CSR_HEIGHT:    cfg_in.expected_height = wr_data[15:0];
            jsdc_pkg::CSR_MAX_BYTES: cfg_in.max_image_bytes = wr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_width  <= '0;
         cfg_ff.expected_height <= '0;
         cfg_ff.max_image_bytes <= jsdc_pkg::MAX_BYTES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- rtl/jsdc_parser.sv -----
`default_nettype none
module jsdc_parser #(
   parameter int COUNT_BITS = jsdc_pkg::COUNT_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_fire,
   input  wire jsdc_pkg::req_type req,
   input  wire jsdc_pkg::cfg_type cfg,
   output jsdc_pkg::rsp_type      result
);

   localparam int EW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
   localparam int SW = (COUNT_BITS > 24) ? COUNT_BITS : 24;
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
   localparam logic [EW-1:0] CMAX_E = EW'(CMAX);

   logic [COUNT_BITS-1:0] cnt_ff, cnt_in, cnt_plus;
   logic [COUNT_BITS-1:0] msp_ff, msp_in;
   logic [COUNT_BITS:0]   send_ff, send_in;
   logic [15:0]           slen_ff, slen_in;
   logic [2:0]            spos_ff, spos_in;
   logic [15:0]           hh_ff, hh_in, hw_ff, hw_in;
   logic                  hseen_ff, hseen_in;
   logic [7:0]            prev_ff, prev_in;
   jsdc_pkg::phase_type   ph_ff, ph_in;
   jsdc_pkg::err_type     err_ff, err_in;

   logic [7:0]            d;
   logic                  sat;
   logic [15:0]           len_full;
   logic [EW-1:0]         seg_end;
   logic [COUNT_BITS+1:0] msp_plus3;
   logic                  frame_bad;
   logic                  no_hdr;
   logic                  hdr_ok;
   logic                  dims_eq;
   jsdc_pkg::status_type  st;

   function automatic logic is_sof(input logic [7:0] m);
      is_sof = (m >= jsdc_pkg::MK_SOF_LO) && (m <= jsdc_pkg::MK_SOF_HI) &&
               (m != jsdc_pkg::MK_DHT) && (m != jsdc_pkg::MK_JPG) &&
               (m != jsdc_pkg::MK_DAC);
   endfunction

   assign d        = req.data_byte;
   assign sat      = (cnt_ff == CMAX);
   assign cnt_plus = cnt_ff + 1'b1;
   assign len_full = {slen_ff[15:8], d};
   assign seg_end  = EW'(cnt_ff) - EW'(1) + EW'(len_full);

   always_comb begin
      cnt_in   = sat ? cnt_ff : cnt_plus;
      msp_in   = msp_ff;
      send_in  = send_ff;
      slen_in  = slen_ff;
      spos_in  = spos_ff;
      hh_in    = hh_ff;
      hw_in    = hw_ff;
      hseen_in = hseen_ff;
      prev_in  = d;
      ph_in    = ph_ff;
      err_in   = sat ? jsdc_pkg::ERR_FRAME : err_ff;
      if (err_in != jsdc_pkg::ERR_FRAME) begin
         unique case (ph_ff) inside
            jsdc_pkg::PH_SOI0: begin
               if (d != jsdc_pkg::MK_FILL) err_in = jsdc_pkg::ERR_FRAME;
               ph_in = jsdc_pkg::PH_SOI1;
            end
            jsdc_pkg::PH_SOI1: begin
               if (d != jsdc_pkg::MK_SOI) err_in = jsdc_pkg::ERR_FRAME;
               msp_in = cnt_plus;
               ph_in  = jsdc_pkg::PH_EXPECT;
            end
            jsdc_pkg::PH_EXPECT: begin
               if (d != jsdc_pkg::MK_FILL) begin
                  if (err_in == jsdc_pkg::ERR_NONE) err_in = jsdc_pkg::ERR_SEG;
                  ph_in = jsdc_pkg::PH_DONE;
               end else begin
                  ph_in = jsdc_pkg::PH_FILL;
               end
            end
            jsdc_pkg::PH_FILL: begin
               if (d == jsdc_pkg::MK_FILL) begin
                  ph_in = jsdc_pkg::PH_FILL;
               end else if (d == jsdc_pkg::MK_EOI || d == jsdc_pkg::MK_SOS) begin
                  if (err_in == jsdc_pkg::ERR_NONE) err_in = jsdc_pkg::ERR_SEG;
                  ph_in = jsdc_pkg::PH_DONE;
               end else if (d == jsdc_pkg::MK_TEM ||
                            (d >= jsdc_pkg::MK_RST_LO && d <= jsdc_pkg::MK_RST_HI)) begin
                  msp_in = cnt_plus;
                  ph_in  = jsdc_pkg::PH_EXPECT;
               end else begin
                  ph_in = is_sof(d) ? jsdc_pkg::PH_SOFHI : jsdc_pkg::PH_LENHI;
               end
            end
            jsdc_pkg::PH_LENHI, jsdc_pkg::PH_SOFHI: begin
               slen_in = {d, 8'h00};
               ph_in   = (ph_ff == jsdc_pkg::PH_SOFHI) ? jsdc_pkg::PH_SOFLO
                                                       : jsdc_pkg::PH_LENLO;
            end
            jsdc_pkg::PH_LENLO, jsdc_pkg::PH_SOFLO: begin
               slen_in = len_full;
               if (len_full < 16'd2) begin
                  if (err_in == jsdc_pkg::ERR_NONE) err_in = jsdc_pkg::ERR_SEG;
                  ph_in = jsdc_pkg::PH_DONE;
               end else begin
                  send_in = (seg_end > CMAX_E) ? {1'b1, {COUNT_BITS{1'b0}}}
                                               : seg_end[COUNT_BITS:0];
                  if (ph_ff == jsdc_pkg::PH_SOFLO) begin
                     if (len_full < 16'd8) begin
                        if (err_in == jsdc_pkg::ERR_NONE) err_in = jsdc_pkg::ERR_SEG;
                        ph_in = jsdc_pkg::PH_DONE;
                     end else begin
                        hseen_in = 1'b1;
                        spos_in  = '0;
                        ph_in    = jsdc_pkg::PH_SOFBODY;
                     end
                  end else if (len_full == 16'd2) begin
                     msp_in = cnt_plus;
                     ph_in  = jsdc_pkg::PH_EXPECT;
                  end else begin
                     ph_in = jsdc_pkg::PH_SKIP;
                  end
               end
            end
            jsdc_pkg::PH_SKIP: begin
               if ({1'b0, cnt_plus} == send_ff) begin
                  msp_in = cnt_plus;
                  ph_in  = jsdc_pkg::PH_EXPECT;
               end
            end
            jsdc_pkg::PH_SOFBODY: begin
               case (spos_ff)
                  3'd1:    hh_in = {d, 8'h00};
                  3'd2:    hh_in = {hh_ff[15:8], d};
                  3'd3:    hw_in = {d, 8'h00};
                  3'd4: begin
                     hw_in = {hw_ff[15:8], d};
                     ph_in = jsdc_pkg::PH_DONE;
                  end
                  default: hh_in = hh_ff;
               endcase
               spos_in = spos_ff + 3'd1;
            end
            default: ph_in = ph_ff;
         endcase
      end
   end

   // Verdict on the final byte, taken from the updated state
   assign msp_plus3 = {2'b00, msp_in} + (COUNT_BITS+2)'(3);
   assign frame_bad = (err_in == jsdc_pkg::ERR_FRAME) || (cnt_in < COUNT_BITS'(4)) ||
                      (SW'(cnt_in) > SW'(cfg.max_image_bytes)) ||
                      (prev_ff != jsdc_pkg::MK_FILL) || (d != jsdc_pkg::MK_EOI);
   assign no_hdr    = msp_plus3 >= {2'b00, cnt_in};
   assign hdr_ok    = hseen_in && (ph_in == jsdc_pkg::PH_DONE) &&
                      (send_in <= {1'b0, cnt_in});
   assign dims_eq   = (hw_in == cfg.expected_width) && (hh_in == cfg.expected_height);

   always_comb begin
      if (frame_bad)                     st = jsdc_pkg::ST_FRAME;
      else if (no_hdr)                   st = jsdc_pkg::ST_NOHDR;
      else if (err_in == jsdc_pkg::ERR_SEG) st = jsdc_pkg::ST_SEG;
      else if (hdr_ok)                   st = dims_eq ? jsdc_pkg::ST_MATCH : jsdc_pkg::ST_DIM;
      else                               st = jsdc_pkg::ST_SEG;
      result.matched      = (st == jsdc_pkg::ST_MATCH);
      result.status       = st;
      result.found_width  = (st == jsdc_pkg::ST_MATCH || st == jsdc_pkg::ST_DIM) ? hw_in : '0;
      result.found_height = (st == jsdc_pkg::ST_MATCH || st == jsdc_pkg::ST_DIM) ? hh_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (in_fire && req.last_byte)) begin
         cnt_ff   <= '0;
         msp_ff   <= '0;
         send_ff  <= '0;
         slen_ff  <= '0;
         spos_ff  <= '0;
         hh_ff    <= '0;
         hw_ff    <= '0;
         hseen_ff <= 1'b0;
         prev_ff  <= '0;
         ph_ff    <= jsdc_pkg::PH_SOI0;
         err_ff   <= jsdc_pkg::ERR_NONE;
      end else if (in_fire) begin
         cnt_ff   <= cnt_in;
         msp_ff   <= msp_in;
         send_ff  <= send_in;
         slen_ff  <= slen_in;
         spos_ff  <= spos_in;
         hh_ff    <= hh_in;
         hw_ff    <= hw_in;
         hseen_ff <= hseen_in;
         prev_ff  <= prev_in;
         ph_ff    <= ph_in;
         err_ff   <= err_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/jsdc_out.sv -----
`default_nettype none
module jsdc_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire jsdc_pkg::rsp_type result,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output jsdc_pkg::rsp_type      rsp
);

   logic              valid_ff, valid_in;
   jsdc_pkg::rsp_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule
`default_nettype wire
